// ===== sv/abrbf_pkg.sv =====
// abrbf_pkg: shared types, constants and command structs for the bandwidth
// filter and rate select block. No dependencies.
package abrbf_pkg;

    localparam int HISTORY_DEPTH_DEF = 10;
    localparam int MAX_LEVELS_DEF    = 8;

    localparam int BW_W      = 32;
    localparam int BUF_W     = 24;
    localparam int RATE_W    = 20;
    localparam int UTIL_W    = 24;
    localparam int VP_W      = 40;
    localparam int GP_W      = 24;
    localparam int NLEV_W    = 4;
    localparam int LEVEL_W   = 3;
    localparam int SUM_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 40;
    localparam int NUM_W     = 66;

    localparam logic [16:0] ALPHA_Q16     = 17'd6554;
    localparam logic [16:0] ALPHA_INV_Q16 = 17'd58982;

    localparam logic [CFG_IDX_W-1:0] CFG_VP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NLEV = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECIDE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [2:0]         level_index;
        logic [RATE_W-1:0]  level_rate;
        logic [UTIL_W-1:0]  level_utility;
        logic [BW_W-1:0]    raw_bandwidth;
        logic [BUF_W-1:0]   buffer_ms;
    } abrbf_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] chosen_level;
        logic [BW_W-1:0]    used_bandwidth;
        logic               smoothed_flag;
        logic               oscillation_flag;
        logic [SUM_W-1:0]   rate_total;
    } abrbf_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // write level table
        logic push;        // push history, latch inputs
        logic scan_init;   // start history scan
        logic scan_step;   // one history entry
        logic lvl_init;    // start level loop
        logic mul_hi;      // latch level rate, form utility + GP sum
        logic mul_lo;      // multiply V high and low parts
        logic num_form;    // form numerator
        logic div_start;
        logic lvl_update;  // compare score, next level
        logic lvl_skip;    // unaffordable level, next level
        logic finish;      // accumulate and present result
    } abrbf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic lvl_done;
        logic div_done;
        logic afford;
    } abrbf_sts_t;

endpackage

// ===== sv/abrbf_div.sv =====
// abrbf_div: signed-numerator by unsigned-divisor radix-2 divider, truncating
// toward zero. Depends on abrbf_pkg.
module abrbf_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [abrbf_pkg::NUM_W-1:0]   num,
    input  logic [abrbf_pkg::RATE_W-1:0]         den,
    output logic                                 done,
    output logic signed [abrbf_pkg::NUM_W-1:0]   quo
);
    localparam int CNT_W = $clog2(abrbf_pkg::NUM_W + 1);

    logic [abrbf_pkg::NUM_W-1:0]  q_reg, q_next;
    logic [abrbf_pkg::RATE_W:0]   r_reg, r_next;
    logic [abrbf_pkg::RATE_W-1:0] d_reg, d_next;
    logic                         neg_reg, neg_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [abrbf_pkg::RATE_W+1:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            neg_next  = num[abrbf_pkg::NUM_W-1];
            q_next    = num[abrbf_pkg::NUM_W-1] ? (~num + 1'b1) : num;
            d_next    = (den == '0) ? {{(abrbf_pkg::RATE_W-1){1'b0}}, 1'b1} : den;
            r_next    = '0;
            cnt_next  = CNT_W'(abrbf_pkg::NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[abrbf_pkg::NUM_W-1]} - {2'b00, d_reg};
            if (!trial[abrbf_pkg::RATE_W+1])
            begin
                r_next = trial[abrbf_pkg::RATE_W:0];
                q_next = {q_reg[abrbf_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[abrbf_pkg::RATE_W-1:0], q_reg[abrbf_pkg::NUM_W-1]};
                q_next = {q_reg[abrbf_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? $signed(~q_reg + 1'b1) : $signed(q_reg);

endmodule

// ===== sv/abrbf_datapath.sv =====
// abrbf_datapath: history shift line, smoothing and oscillation scan, level
// table, score arithmetic and running total. Depends on abrbf_pkg, abrbf_div.
module abrbf_datapath #(
    parameter int HISTORY_DEPTH = abrbf_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_LEVELS    = abrbf_pkg::MAX_LEVELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  abrbf_pkg::abrbf_cmd_t              cmd,
    output abrbf_pkg::abrbf_sts_t              sts,
    input  abrbf_pkg::abrbf_in_t               word_in,
    input  logic [abrbf_pkg::VP_W-1:0]         vp,
    input  logic [abrbf_pkg::GP_W-1:0]         gp,
    input  logic [abrbf_pkg::NLEV_W-1:0]       nlev,
    output abrbf_pkg::abrbf_out_t              result
);
    localparam int HW = $clog2(HISTORY_DEPTH + 1);
    localparam int HI = $clog2(HISTORY_DEPTH);
    localparam int LW = $clog2(MAX_LEVELS + 1);
    localparam int LI = $clog2(MAX_LEVELS);
    localparam logic [abrbf_pkg::SUM_W-1:0] SUM_MAX = '1;

    logic [abrbf_pkg::BW_W-1:0]   hist_reg [HISTORY_DEPTH];
    logic [HW-1:0]                fill_reg;
    logic [abrbf_pkg::RATE_W-1:0] rate_mem [MAX_LEVELS];
    logic [abrbf_pkg::UTIL_W-1:0] util_mem [MAX_LEVELS];

    logic [abrbf_pkg::BW_W-1:0]   raw_reg;
    logic [abrbf_pkg::BUF_W-1:0]  buf_reg;
    logic [HW:0]                  hidx_reg;
    logic [abrbf_pkg::BW_W-1:0]   smooth_reg;
    logic                         up_reg, down_reg;
    logic [abrbf_pkg::BW_W-1:0]   bw_reg;
    logic                         osc_reg, sm_reg;
    logic [LW-1:0]                lidx_reg;
    logic [LW-1:0]                nlim_reg;
    logic [abrbf_pkg::RATE_W-1:0] cur_rate_reg;
    logic [abrbf_pkg::UTIL_W:0]   s_reg;
    logic [48:0]                  ph_reg;
    logic [40:0]                  pl_reg;
    logic signed [abrbf_pkg::NUM_W-1:0] num_reg;
    logic signed [abrbf_pkg::NUM_W-1:0] best_score_reg;
    logic                         found_reg;
    logic [LI-1:0]                best_reg;
    logic [abrbf_pkg::SUM_W-1:0]  sum_reg;
    abrbf_pkg::abrbf_out_t        result_reg;

    logic [HW-1:0]                fill_new;
    logic [abrbf_pkg::BW_W-1:0]   h_cur, h_prev;
    logic [49:0]                  sm_sum;
    logic                         drop;
    logic                         osc;
    logic [LW-1:0]                nsel;
    logic                         div_done;
    logic signed [abrbf_pkg::NUM_W-1:0] quo;
    logic [abrbf_pkg::RATE_W-1:0] best_rate;
    logic [abrbf_pkg::SUM_W:0]    sum_add;
    logic                         skip;

    assign fill_new = (fill_reg >= HW'(HISTORY_DEPTH)) ? HW'(HISTORY_DEPTH) : fill_reg + 1'b1;
    assign h_cur    = hist_reg[hidx_reg[HI-1:0]];
    assign h_prev   = hist_reg[HI'(fill_reg - 2'd2)];

    always_comb
    begin
        if (nlev == '0)
            nsel = LW'(1);
        else if (LW'(nlev) > LW'(MAX_LEVELS) || 32'(nlev) > MAX_LEVELS)
            nsel = LW'(MAX_LEVELS);
        else
            nsel = LW'(nlev);
    end

    // history shift line: oldest at entry 0
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            if (fill_reg >= HW'(HISTORY_DEPTH))
            begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                    hist_reg[i] <= hist_reg[i+1];
                hist_reg[HISTORY_DEPTH-1] <= word_in.raw_bandwidth;
            end
            else
                hist_reg[fill_reg[HI-1:0]] <= word_in.raw_bandwidth;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && 32'(word_in.level_index) < MAX_LEVELS)
        begin
            rate_mem[LI'(word_in.level_index)] <= word_in.level_rate;
            util_mem[LI'(word_in.level_index)] <= word_in.level_utility;
        end
    end

    assign sm_sum = 50'(abrbf_pkg::ALPHA_Q16) * 50'(h_cur)
                  + 50'(abrbf_pkg::ALPHA_INV_Q16) * 50'(smooth_reg) + 50'd32768;
    assign drop   = (fill_reg > HW'(1)) && ({raw_reg, 1'b0} < {1'b0, h_prev});
    assign osc    = (fill_reg == HW'(HISTORY_DEPTH)) && up_reg && down_reg;
    assign best_rate = rate_mem[best_reg];
    assign sum_add   = {1'b0, sum_reg} + (abrbf_pkg::SUM_W+1)'(best_rate);

    // unaffordable level
    assign skip = ({4'h0, rate_mem[lidx_reg[LI-1:0]], 8'h00} > bw_reg);

    abrbf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (cur_rate_reg),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            if (cmd.push)
                fill_reg <= fill_new;
            if (cmd.finish)
                sum_reg <= sum_add[abrbf_pkg::SUM_W] ? SUM_MAX : sum_add[abrbf_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            raw_reg <= word_in.raw_bandwidth;
            buf_reg <= word_in.buffer_ms;
        end
        if (cmd.scan_init)
        begin
            smooth_reg <= hist_reg[HI'(fill_reg - 1'b1)];
            hidx_reg   <= {1'b0, fill_reg} - (HW+1)'(2);
            up_reg     <= 1'b0;
            down_reg   <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            // entry hidx vs entry hidx+1
            if (hist_reg[HI'(hidx_reg + 1'b1)] > h_cur)
                up_reg <= 1'b1;
            else if (hist_reg[HI'(hidx_reg + 1'b1)] < h_cur)
                down_reg <= 1'b1;
            smooth_reg <= sm_sum[47:16];
            hidx_reg   <= hidx_reg - 1'b1;
        end
        if (cmd.lvl_init)
        begin
            bw_reg    <= (osc || drop) ? smooth_reg : raw_reg;
            sm_reg    <= osc || drop;
            osc_reg   <= osc;
            lidx_reg  <= '0;
            nlim_reg  <= nsel;
            found_reg <= 1'b0;
            best_reg  <= '0;
        end
        if (cmd.mul_hi)
        begin
            cur_rate_reg <= rate_mem[lidx_reg[LI-1:0]];
            s_reg        <= (abrbf_pkg::UTIL_W+1)'(util_mem[lidx_reg[LI-1:0]]) + 25'(gp);
        end
        if (cmd.mul_lo)
        begin
            ph_reg <= 49'(vp[39:16]) * 49'(s_reg);
            pl_reg <= 41'(vp[15:0]) * 41'(s_reg);
        end
        if (cmd.num_form)
            num_reg <= $signed(abrbf_pkg::NUM_W'(ph_reg) + abrbf_pkg::NUM_W'(pl_reg[40:16]))
                     - $signed(abrbf_pkg::NUM_W'({buf_reg, 16'h0000}));
        if (cmd.lvl_update)
        begin
            if (!found_reg || quo > best_score_reg)
            begin
                found_reg      <= 1'b1;
                best_score_reg <= quo;
                best_reg       <= lidx_reg[LI-1:0];
            end
            lidx_reg <= lidx_reg + 1'b1;
        end
        if (cmd.lvl_skip)
            lidx_reg <= lidx_reg + 1'b1;
        if (cmd.finish)
        begin
            result_reg.chosen_level     <= abrbf_pkg::LEVEL_W'(best_reg);
            result_reg.used_bandwidth   <= bw_reg;
            result_reg.smoothed_flag    <= sm_reg;
            result_reg.oscillation_flag <= osc_reg;
            result_reg.rate_total       <= sum_add[abrbf_pkg::SUM_W] ? SUM_MAX
                                          : sum_add[abrbf_pkg::SUM_W-1:0];
        end
    end

    assign sts.scan_done = (hidx_reg[HW] == 1'b1) || (fill_reg < HW'(2));
    assign sts.lvl_done  = (lidx_reg >= nlim_reg);
    assign sts.div_done  = div_done;
    assign sts.afford    = !skip;
    assign result        = result_reg;

endmodule

// ===== sv/abrbf_ctrl.sv =====
// abrbf_ctrl: sequencer for load and decide words; drives the datapath
// through command structs. Depends on abrbf_pkg.
module abrbf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   opcode,
    output logic                   busy,
    output logic                   done,
    output abrbf_pkg::abrbf_cmd_t  cmd,
    input  abrbf_pkg::abrbf_sts_t  sts
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_LVL  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_NUM  = 4'd5;
    localparam logic [3:0] S_DIVS = 4'd6;
    localparam logic [3:0] S_DIVW = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == abrbf_pkg::OP_LOAD)
                        cmd.load = 1'b1;
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.lvl_init = 1'b1;
                    state_next   = S_LVL;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_LVL:
            begin
                if (sts.lvl_done)
                    state_next = S_FIN;
                else if (!sts.afford)
                    cmd.lvl_skip = 1'b1;
                else
                begin
                    cmd.mul_hi = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                cmd.num_form = 1'b1;
                state_next   = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (sts.div_done)
                begin
                    cmd.lvl_update = 1'b1;
                    state_next     = S_LVL;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == S_DIVW)
        else $error("divider start without wait");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> done)
        else $error("finish not followed by result");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result");

endmodule

// ===== sv/abr_bandwidth_filter_and_rate_select.sv =====
// abr_bandwidth_filter_and_rate_select: top level, register port and glue.
// Depends on abrbf_pkg, abrbf_ctrl, abrbf_datapath.
//
// A load word is written in the idle state without raising busy. A decide
// word pushes the history, scans it (up to HISTORY_DEPTH entries), then visits
// each level up to the level count; unaffordable levels are skipped and each
// affordable level runs the radix-2 divider (66 steps). busy stays high while
// a decide word runs; the result appears with done for one cycle and cannot be
// stalled.
module abr_bandwidth_filter_and_rate_select #(
    parameter int HISTORY_DEPTH = abrbf_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_LEVELS    = abrbf_pkg::MAX_LEVELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  abrbf_pkg::abrbf_in_t               word_in,
    output logic                               done,
    output abrbf_pkg::abrbf_out_t              word_out,
    input  logic                               cfg_we,
    input  logic [abrbf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [abrbf_pkg::CFG_DAT_W-1:0]    cfg_data
);
    logic [abrbf_pkg::VP_W-1:0]   vp_reg;
    logic [abrbf_pkg::GP_W-1:0]   gp_reg;
    logic [abrbf_pkg::NLEV_W-1:0] nlev_reg;
    abrbf_pkg::abrbf_cmd_t        cmd;
    abrbf_pkg::abrbf_sts_t        sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg   <= '0;
            gp_reg   <= '0;
            nlev_reg <= abrbf_pkg::NLEV_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                abrbf_pkg::CFG_VP:   vp_reg   <= cfg_data[abrbf_pkg::VP_W-1:0];
                abrbf_pkg::CFG_GP:   gp_reg   <= cfg_data[abrbf_pkg::GP_W-1:0];
                abrbf_pkg::CFG_NLEV: nlev_reg <= cfg_data[abrbf_pkg::NLEV_W-1:0];
                default: ;
            endcase
        end
    end

    abrbf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (word_in.opcode),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .sts    (sts)
    );

    abrbf_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_LEVELS    (MAX_LEVELS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .word_in (word_in),
        .vp      (vp_reg),
        .gp      (gp_reg),
        .nlev    (nlev_reg),
        .result  (word_out)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for abr_bandwidth_filter_and_rate_select.
// Predicts each decide word (history filter, score search, running total).
// Depends on abrbf_pkg and the block's RTL.
module tb_top;
    import abrbf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HIST_N = HISTORY_DEPTH_DEF;
    localparam int LEV_N = MAX_LEVELS_DEF;
    localparam int SETTLE_CYCLES = 700;
    localparam int STALL_LIMIT = 20000;

    class rate_select_scoreboard;
        logic [VP_W-1:0] vp;
        logic [GP_W-1:0] gp;
        logic [NLEV_W-1:0] nlev;
        logic [BW_W-1:0] hist [HIST_N];
        int fill;
        logic [RATE_W-1:0] rates [LEV_N];
        logic [UTIL_W-1:0] utils [LEV_N];
        logic [SUM_W-1:0] total;
        abrbf_out_t pending [$];
        int errors;

        function new();
            vp = '0;
            gp = '0;
            nlev = NLEV_W'(1);
            fill = 0;
            total = '0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("tb_top: mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            if (idx == CFG_VP)
                vp = val[VP_W-1:0];
            else if (idx == CFG_GP)
                gp = val[GP_W-1:0];
            else if (idx == CFG_NLEV)
                nlev = val[NLEV_W-1:0];
        endfunction

        function longint level_score(int lv, longint unsigned bufms);
            longint unsigned s;
            longint unsigned p;
            longint num;
            longint d;
            s = longint'(utils[lv]) + longint'(gp);
            p = (vp >> 16) * s + (((vp & 40'hFFFF) * s) >> 16);
            num = longint'(p) - longint'(bufms << 16);
            d = (rates[lv] != 0) ? longint'(rates[lv]) : 1;
            return num / d;
        endfunction

        function void note(abrbf_in_t w);
            abrbf_out_t r;
            longint unsigned bw;
            longint unsigned sm;
            longint best_sc;
            longint sc;
            int up;
            int down;
            int n;
            int best;
            bit osc;
            bit drop;
            bit found;
            if (w.opcode == OP_LOAD)
            begin
                rates[w.level_index] = w.level_rate;
                utils[w.level_index] = w.level_utility;
                return;
            end
            if (fill >= HIST_N)
            begin
                for (int i = 0; i < HIST_N - 1; i++)
                    hist[i] = hist[i + 1];
                fill = HIST_N - 1;
            end
            hist[fill] = w.raw_bandwidth;
            fill++;
            up = 0;
            down = 0;
            if (fill >= HIST_N)
                for (int i = 1; i < fill; i++)
                begin
                    if (hist[i] > hist[i - 1])
                        up++;
                    else if (hist[i] < hist[i - 1])
                        down++;
                end
            osc = (up > 0) && (down > 0);
            drop = (fill > 1) &&
                   (2 * longint'(w.raw_bandwidth) < longint'(hist[fill - 2]));
            bw = w.raw_bandwidth;
            if (osc || drop)
            begin
                sm = hist[fill - 1];
                for (int i = fill - 2; i >= 0; i--)
                    sm = (64'd6554 * hist[i] + 64'd58982 * sm + 64'd32768) >> 16;
                bw = sm;
            end
            n = (nlev < 1) ? 1 : (nlev > LEV_N) ? LEV_N : nlev;
            best = 0;
            best_sc = 0;
            found = 0;
            for (int i = 0; i < n; i++)
            begin
                if ((longint'(rates[i]) << 8) <= bw)
                begin
                    sc = level_score(i, w.buffer_ms);
                    if (!found || sc > best_sc)
                    begin
                        found = 1;
                        best_sc = sc;
                        best = i;
                    end
                end
            end
            if (total > {SUM_W{1'b1}} - rates[best])
                total = {SUM_W{1'b1}};
            else
                total = total + rates[best];
            r.chosen_level = LEVEL_W'(best);
            r.used_bandwidth = bw[BW_W-1:0];
            r.smoothed_flag = osc || drop;
            r.oscillation_flag = osc;
            r.rate_total = total;
            pending = {pending, r};
        endfunction

        task check(abrbf_out_t got);
            abrbf_out_t e;
            if (pending.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.chosen_level !== e.chosen_level)
                report($sformatf("chosen_level %0d exp %0d", got.chosen_level,
                                 e.chosen_level));
            if (got.used_bandwidth !== e.used_bandwidth)
                report($sformatf("used_bandwidth %0h exp %0h", got.used_bandwidth,
                                 e.used_bandwidth));
            if (got.smoothed_flag !== e.smoothed_flag)
                report($sformatf("smoothed_flag %0b exp %0b", got.smoothed_flag,
                                 e.smoothed_flag));
            if (got.oscillation_flag !== e.oscillation_flag)
                report($sformatf("oscillation_flag %0b exp %0b",
                                 got.oscillation_flag, e.oscillation_flag));
            if (got.rate_total !== e.rate_total)
                report($sformatf("rate_total %0h exp %0h", got.rate_total,
                                 e.rate_total));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    abrbf_in_t word_in;
    logic done;
    abrbf_out_t word_out;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    rate_select_scoreboard sb;
    int stall_cycles;
    int idle_pct;
    logic [BW_W-1:0] last_bw;

    abr_bandwidth_filter_and_rate_select DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .word_in(word_in),
        .done(done),
        .word_out(word_out),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(word_out);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done || (start && !busy) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send(abrbf_in_t w);
        @(negedge clk);
        start = 1'b1;
        word_in = w;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note(w);
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(40)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_regs(longint unsigned vp, longint unsigned gp, int n);
        drain();
        write_reg(CFG_VP, vp);
        write_reg(CFG_GP, gp);
        write_reg(CFG_NLEV, n);
    endtask

    function automatic abrbf_in_t load_word(int idx, int rate, int util);
        abrbf_in_t w;
        w = '0;
        w.opcode = OP_LOAD;
        w.level_index = idx;
        w.level_rate = rate;
        w.level_utility = util;
        w.raw_bandwidth = $urandom();
        w.buffer_ms = $urandom();
        return w;
    endfunction

    function automatic abrbf_in_t decide_word(logic [BW_W-1:0] bw, int bufms);
        abrbf_in_t w;
        w = '0;
        w.opcode = OP_DECIDE;
        w.level_index = $urandom();
        w.level_rate = $urandom();
        w.level_utility = $urandom();
        w.raw_bandwidth = bw;
        w.buffer_ms = bufms;
        return w;
    endfunction

    function automatic logic [BW_W-1:0] next_bw(int mode);
        case (mode)
            0: return last_bw + $urandom_range(1, 4096);
            1: return last_bw - $urandom_range(1, 4096);
            2: return $urandom();
            default: return $urandom_range(0, 32'h0FFF_FFFF);
        endcase
    endfunction

    task automatic random_phase(int count);
        int mode;
        for (int k = 0; k < count; k++)
        begin
            if (k % 16 == 0)
                mode = $urandom_range(3);
            if ($urandom_range(99) < 25)
            begin
                send(load_word($urandom_range(LEV_N - 1),
                               ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 20'hFFFFF),
                               $urandom()));
            end
            else
            begin
                last_bw = next_bw(mode);
                send(decide_word(last_bw, ($urandom_range(3) == 0) ? $urandom() :
                                 $urandom_range(0, 30000)));
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        word_in = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stall_cycles = 0;
        idle_pct = 0;
        last_bw = 32'h0010_0000;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, drop, rising history, oscillation
        write_reg(CFG_VP, {VP_W{1'b1}});
        write_reg(CFG_GP, {GP_W{1'b1}});
        write_reg(CFG_NLEV, LEV_N);
        write_reg(CFG_UNUSED, {CFG_DAT_W{1'b1}});
        send(load_word(0, 20'hFFFFF, 24'hFFFFFF));
        send(load_word(1, 0, 0));
        for (int i = 2; i < LEV_N; i++)
            send(load_word(i, 100 * i, 24'h010000 * i));
        send(decide_word(0, 0));
        send(decide_word(32'hFFFF_FFFF, 24'hFFFFFF));
        send(decide_word(32'h0000_1000, 100));
        send(decide_word(32'h0000_07FF, 100));
        for (int i = 0; i < 7; i++)
            send(decide_word(32'h0001_0000 * (i + 1), 50));
        send(decide_word(32'h0000_8000, 0));
        send(decide_word(32'h0009_0000, 0));

        set_regs(0, 0, 0);
        idle_pct = 19;
        random_phase(150);
        set_regs({VP_W{1'b1}}, 0, 15);
        random_phase(150);
        drain();
        idle_pct = 54;
        set_regs($urandom_range(1, 32'hFFFF_FFFF), $urandom(), 3);
        random_phase(150);
        set_regs({$urandom(), $urandom()}, {GP_W{1'b1}}, 9);
        random_phase(150);
        idle_pct = 0;
        set_regs({$urandom(), $urandom()}, $urandom(), $urandom_range(1, LEV_N));
        random_phase(200);

        drain();
        while (sb.pending.size() != 0)
        begin
            sb.report("expected result never arrived");
            void'(sb.pending.pop_front());
        end
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
